@@ rtl/core/union_find_connectivity_core_defines.svh @@
// ---------------------------------------------------------------------------
// Union-find connectivity core: assertion macros
// Shared property wrappers, clocked on i_clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef UNION_FIND_CONNECTIVITY_CORE_DEFINES_SVH
`define UNION_FIND_CONNECTIVITY_CORE_DEFINES_SVH

// same-cycle implication
`define UFC_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UFC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ufc_pkg.sv @@
// ---------------------------------------------------------------------------
// ufc_pkg
// Beat types, register codes and sequencer states of the union-find core.
// ---------------------------------------------------------------------------
package ufc_pkg;

    // mode register codes
    localparam logic [1:0] MODE_QFIND    = 2'd0;
    localparam logic [1:0] MODE_QUNION   = 2'd1;
    localparam logic [1:0] MODE_WEIGHTED = 2'd2;

    // register word index of the mode register
    localparam logic REG_MODE = 1'b0;

    localparam int unsigned ELEM_W  = 7;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned SIZE_W  = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [SIZE_W-1:0]  SIZE_MAX  = '1;
    localparam logic [SIZE_W-1:0]  SIZE_ONE  = 8'd1;

    typedef struct packed {
        logic [ELEM_W-1:0] first_element;
        logic [ELEM_W-1:0] second_element;
    } t_in_beat;

    typedef struct packed {
        logic               joined;
        logic [COUNT_W-1:0] unions_so_far;
    } t_out_beat;

    // write strobes towards the parent and size memories
    typedef struct packed {
        logic par_we;
        logic size_we;
    } t_store_ctl;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QF_A,
        ST_QF_B,
        ST_QF_SCAN,
        ST_WALK_A,
        ST_WALK_B,
        ST_SIZE_A,
        ST_SIZE_B,
        ST_DONE
    } t_state;

endpackage

@@ rtl/core/union_find_connectivity_core.sv @@
// ---------------------------------------------------------------------------
// union_find_connectivity_core
// Pairwise union-find: quick-find, quick-union or weighted quick-union.
// ---------------------------------------------------------------------------
// Operation: quick-find reads both labels and, if they differ, runs one
//   relabel sweep over all entries; quick-union and weighted walk both roots
//   (weighted then reads both tree sizes unless already joined); an out-of-range pair goes straight to the result.
// Throughput: one beat at a time; next beat taken once the result is queued.
// Reset: synchronous, active low; a clearing pass then
//   rewrites parent and size memories, input not ready meanwhile.
`include "union_find_connectivity_core_defines.svh"

module union_find_connectivity_core #(
    parameter int unsigned SET_COUNT = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ufc_pkg::t_in_beat  i_in_data,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ufc_pkg::t_out_beat o_out_data,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int unsigned IDX_W = $clog2(SET_COUNT);
    localparam int unsigned HOP_W = $clog2(SET_COUNT + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SET_COUNT - 1);
    localparam logic [HOP_W-1:0] HOP_LIM  = HOP_W'(SET_COUNT);

    ufc_pkg::t_state r_state, n_state;

    logic [1:0]                  r_mode;
    logic [IDX_W-1:0]            r_clr, n_clr;
    logic [IDX_W-1:0]            r_x, n_x;
    logic [HOP_W-1:0]            r_hops, n_hops;
    logic [IDX_W-1:0]            r_b, n_b;
    logic [IDX_W-1:0]            r_ra, n_ra;
    logic [IDX_W-1:0]            r_rb, n_rb;
    logic [IDX_W-1:0]            r_from, n_from;
    logic [IDX_W-1:0]            r_to, n_to;
    logic [HOP_W-1:0]            r_idx, n_idx;
    logic [ufc_pkg::SIZE_W-1:0]  r_sza, n_sza;
    logic                        r_merged, n_merged;
    logic [ufc_pkg::COUNT_W-1:0] r_count, n_count;
    logic                        r_out_vld, n_out_vld;
    ufc_pkg::t_out_beat          r_out, n_out;

    // memory ports
    ufc_pkg::t_store_ctl         c_ctl;
    logic [IDX_W-1:0]            c_par_waddr, c_par_wdata, c_par_raddr, w_par_rdata;
    logic [IDX_W-1:0]            c_size_waddr, c_size_raddr;
    logic [ufc_pkg::SIZE_W-1:0]  c_size_wdata, w_size_rdata;

    // shared datapath terms
    logic                        c_in_fire, c_out_free, c_in_range;
    logic [IDX_W-1:0]            c_a_idx, c_b_idx;
    logic                        c_is_root, c_walk_done;
    logic [HOP_W-1:0]            c_hops_inc, c_idx_dec;
    logic [IDX_W-1:0]            c_root;
    logic [ufc_pkg::SIZE_W:0]    c_sum;
    logic [ufc_pkg::SIZE_W-1:0]  c_sum_sat;
    logic                        c_scan_end;
    logic                        c_wr_cfg;

    ufc_store #(
        .SET_COUNT (SET_COUNT)
    ) u_store (
        .i_clk        (i_clk),
        .i_ctl        (c_ctl),
        .i_par_waddr  (c_par_waddr),
        .i_par_wdata  (c_par_wdata),
        .i_par_raddr  (c_par_raddr),
        .o_par_rdata  (w_par_rdata),
        .i_size_waddr (c_size_waddr),
        .i_size_wdata (c_size_wdata),
        .i_size_raddr (c_size_raddr),
        .o_size_rdata (w_size_rdata)
    );

    // configuration register
    assign c_wr_cfg = psel && penable && pwrite && (paddr[2] == ufc_pkg::REG_MODE);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == ufc_pkg::REG_MODE) ? {30'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ufc_pkg::MODE_WEIGHTED;
        end else if (c_wr_cfg) begin
            r_mode <= pwdata[1:0];
        end
    end

    // handshake terms
    assign c_in_fire  = i_in_valid && o_in_ready;
    assign c_out_free = !r_out_vld || i_out_ready;
    assign c_in_range = (32'(i_in_data.first_element) < SET_COUNT)
                     && (32'(i_in_data.second_element) < SET_COUNT);
    assign c_a_idx    = IDX_W'(i_in_data.first_element);
    assign c_b_idx    = IDX_W'(i_in_data.second_element);

    // root walk step: one parent hop per cycle
    assign c_is_root   = (w_par_rdata == r_x);
    assign c_hops_inc  = r_hops + 1'b1;
    assign c_walk_done = c_is_root || (c_hops_inc == HOP_LIM);
    assign c_root      = c_is_root ? r_x : w_par_rdata;

    // relabel sweep bookkeeping
    assign c_idx_dec  = r_idx - 1'b1;
    assign c_scan_end = (r_idx == HOP_LIM);

    // size sum with saturation
    assign c_sum     = {1'b0, r_sza} + {1'b0, w_size_rdata};
    assign c_sum_sat = c_sum[ufc_pkg::SIZE_W] ? ufc_pkg::SIZE_MAX
                                               : c_sum[ufc_pkg::SIZE_W-1:0];

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ufc_pkg::ST_CLEAR: begin
                if (r_clr == IDX_LAST) begin
                    n_state = ufc_pkg::ST_IDLE;
                end
            end
            ufc_pkg::ST_IDLE: begin
                if (c_in_fire) begin
                    if (!c_in_range) begin
                        n_state = ufc_pkg::ST_DONE;
                    end else if (r_mode == ufc_pkg::MODE_QFIND) begin
                        n_state = ufc_pkg::ST_QF_A;
                    end else begin
                        n_state = ufc_pkg::ST_WALK_A;
                    end
                end
            end
            ufc_pkg::ST_QF_A: n_state = ufc_pkg::ST_QF_B;
            ufc_pkg::ST_QF_B: begin
                n_state = (r_from == w_par_rdata) ? ufc_pkg::ST_DONE : ufc_pkg::ST_QF_SCAN;
            end
            ufc_pkg::ST_QF_SCAN: begin
                if (c_scan_end) begin
                    n_state = ufc_pkg::ST_DONE;
                end
            end
            ufc_pkg::ST_WALK_A: begin
                if (c_walk_done) begin
                    n_state = ufc_pkg::ST_WALK_B;
                end
            end
            ufc_pkg::ST_WALK_B: begin
                if (c_walk_done) begin
                    if (c_root == r_ra || r_mode == ufc_pkg::MODE_QUNION) begin
                        n_state = ufc_pkg::ST_DONE;
                    end else begin
                        n_state = ufc_pkg::ST_SIZE_A;
                    end
                end
            end
            ufc_pkg::ST_SIZE_A: n_state = ufc_pkg::ST_SIZE_B;
            ufc_pkg::ST_SIZE_B: n_state = ufc_pkg::ST_DONE;
            ufc_pkg::ST_DONE: begin
                if (c_out_free) begin
                    n_state = ufc_pkg::ST_IDLE;
                end
            end
            default: n_state = ufc_pkg::ST_IDLE;
        endcase
    end

    // sequencer: outputs, memory ports and datapath updates
    always_comb begin
        o_in_ready   = 1'b0;
        c_ctl        = '0;
        c_par_waddr  = r_ra;
        c_par_wdata  = r_rb;
        c_par_raddr  = r_x;
        c_size_waddr = r_rb;
        c_size_wdata = c_sum_sat;
        c_size_raddr = r_ra;
        n_clr        = r_clr;
        n_x          = r_x;
        n_hops       = r_hops;
        n_b          = r_b;
        n_ra         = r_ra;
        n_rb         = r_rb;
        n_from       = r_from;
        n_to         = r_to;
        n_idx        = r_idx;
        n_sza        = r_sza;
        n_merged     = r_merged;
        n_count      = r_count;
        n_out_vld    = r_out_vld && !i_out_ready;
        n_out        = r_out;
        unique case (r_state)
            ufc_pkg::ST_CLEAR: begin
                // every element its own root, size one
                c_ctl.par_we  = 1'b1;
                c_ctl.size_we = 1'b1;
                c_par_waddr   = r_clr;
                c_par_wdata   = r_clr;
                c_size_waddr  = r_clr;
                c_size_wdata  = ufc_pkg::SIZE_ONE;
                n_clr         = r_clr + 1'b1;
            end
            ufc_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                c_par_raddr = c_a_idx;
                n_x         = c_a_idx;
                n_b         = c_b_idx;
                n_hops      = '0;
                n_merged    = 1'b0;
            end
            ufc_pkg::ST_QF_A: begin
                n_from      = w_par_rdata;
                c_par_raddr = r_b;
            end
            ufc_pkg::ST_QF_B: begin
                n_to     = w_par_rdata;
                n_idx    = '0;
                n_merged = (r_from != w_par_rdata);
            end
            ufc_pkg::ST_QF_SCAN: begin
                // read entry idx, relabel entry idx-1 from last cycle's read
                c_par_raddr = r_idx[IDX_W-1:0];
                c_par_waddr = c_idx_dec[IDX_W-1:0];
                c_par_wdata = r_to;
                if (r_idx != '0 && w_par_rdata == r_from) begin
                    c_ctl.par_we = 1'b1;
                end
                n_idx = r_idx + 1'b1;
            end
            ufc_pkg::ST_WALK_A: begin
                if (c_walk_done) begin
                    n_ra        = c_root;
                    c_par_raddr = r_b;
                    n_x         = r_b;
                    n_hops      = '0;
                end else begin
                    c_par_raddr = w_par_rdata;
                    n_x         = w_par_rdata;
                    n_hops      = c_hops_inc;
                end
            end
            ufc_pkg::ST_WALK_B: begin
                if (c_walk_done) begin
                    n_rb         = c_root;
                    c_size_raddr = r_ra;
                    if (c_root != r_ra) begin
                        n_merged = 1'b1;
                        if (r_mode == ufc_pkg::MODE_QUNION) begin
                            c_ctl.par_we = 1'b1;
                            c_par_waddr  = r_ra;
                            c_par_wdata  = c_root;
                        end
                    end
                end else begin
                    c_par_raddr = w_par_rdata;
                    n_x         = w_par_rdata;
                    n_hops      = c_hops_inc;
                end
            end
            ufc_pkg::ST_SIZE_A: begin
                n_sza        = w_size_rdata;
                c_size_raddr = r_rb;
            end
            ufc_pkg::ST_SIZE_B: begin
                // smaller tree under larger, first under second on a tie
                c_ctl.par_we  = 1'b1;
                c_ctl.size_we = 1'b1;
                if (r_sza <= w_size_rdata) begin
                    c_par_waddr  = r_ra;
                    c_par_wdata  = r_rb;
                    c_size_waddr = r_rb;
                end else begin
                    c_par_waddr  = r_rb;
                    c_par_wdata  = r_ra;
                    c_size_waddr = r_ra;
                end
            end
            ufc_pkg::ST_DONE: begin
                if (c_out_free) begin
                    if (r_merged && r_count != ufc_pkg::COUNT_MAX) begin
                        n_count = r_count + 1'b1;
                    end
                    n_out_vld           = 1'b1;
                    n_out.joined        = r_merged;
                    n_out.unions_so_far = (r_merged && r_count != ufc_pkg::COUNT_MAX)
                                        ? r_count + 1'b1 : r_count;
                end
            end
            default: begin
                n_clr = r_clr;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ufc_pkg::ST_CLEAR;
            r_clr     <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_hops   <= n_hops;
        r_b      <= n_b;
        r_ra     <= n_ra;
        r_rb     <= n_rb;
        r_from   <= n_from;
        r_to     <= n_to;
        r_idx    <= n_idx;
        r_sza    <= n_sza;
        r_merged <= n_merged;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // checks
    `UFC_ASSERT_NEXT(a_count_step, 1'b1, (r_count == $past(r_count)) || (r_count == $past(r_count) + 7'd1), "merge count moved by more than one")
    `UFC_ASSERT_IMPL(a_join_counted, o_out_valid && o_out_data.joined, o_out_data.unions_so_far != '0, "joined beat with zero count")
    `UFC_ASSERT_NEXT(a_accept_busy, i_in_valid && o_in_ready, r_state != ufc_pkg::ST_IDLE, "sequencer stayed idle after accepting a beat")
    `UFC_ASSERT_IMPL(a_no_accept_clear, r_state == ufc_pkg::ST_CLEAR, !o_in_ready && !r_out_vld, "beat activity during clearing pass")

endmodule

@@ rtl/core/ufc_store.sv @@
// ---------------------------------------------------------------------------
// ufc_store
// Parent and size memories: one write and one registered read port each.
// ---------------------------------------------------------------------------
module ufc_store #(
    parameter int unsigned SET_COUNT = 128
) (
    input  logic                       i_clk,
    input  ufc_pkg::t_store_ctl        i_ctl,
    input  logic [$clog2(SET_COUNT)-1:0] i_par_waddr,
    input  logic [$clog2(SET_COUNT)-1:0] i_par_wdata,
    input  logic [$clog2(SET_COUNT)-1:0] i_par_raddr,
    output logic [$clog2(SET_COUNT)-1:0] o_par_rdata,
    input  logic [$clog2(SET_COUNT)-1:0] i_size_waddr,
    input  logic [ufc_pkg::SIZE_W-1:0]   i_size_wdata,
    input  logic [$clog2(SET_COUNT)-1:0] i_size_raddr,
    output logic [ufc_pkg::SIZE_W-1:0]   o_size_rdata
);

    localparam int unsigned IDX_W = $clog2(SET_COUNT);

    logic [IDX_W-1:0]          r_par_mem  [SET_COUNT];
    logic [ufc_pkg::SIZE_W-1:0] r_size_mem [SET_COUNT];
    logic [IDX_W-1:0]          r_par_q;
    logic [ufc_pkg::SIZE_W-1:0] r_size_q;

    // parent links
    always_ff @(posedge i_clk) begin
        if (i_ctl.par_we) begin
            r_par_mem[i_par_waddr] <= i_par_wdata;
        end
        r_par_q <= r_par_mem[i_par_raddr];
    end

    // tree sizes
    always_ff @(posedge i_clk) begin
        if (i_ctl.size_we) begin
            r_size_mem[i_size_waddr] <= i_size_wdata;
        end
        r_size_q <= r_size_mem[i_size_raddr];
    end

    assign o_par_rdata  = r_par_q;
    assign o_size_rdata = r_size_q;

endmodule

@@ sim/tb.sv @@
// ---------------------------------------------------------------------------
// tb: union-find connectivity core testbench
// Sends element pairs under each linking scheme and checks every result beat
// against a cycle-free predictor of parent links, tree sizes and merge count.
// The mode register is changed only between phases, once the core is idle.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ELEMS   = 128;
    localparam int unsigned ELEM_W  = ufc_pkg::ELEM_W;
    localparam int unsigned SIZE_W  = ufc_pkg::SIZE_W;
    localparam int unsigned COUNT_W = ufc_pkg::COUNT_W;
    // mode value 3 is undefined in the register map and decodes as weighted
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [2:0] MODE_ADDR  = 3'(4 * ufc_pkg::REG_MODE);

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    ufc_pkg::t_in_beat  i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    ufc_pkg::t_out_beat o_out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // predictor state
    logic [ELEM_W-1:0]  link_mem  [ELEMS];
    logic [SIZE_W-1:0]  tree_size [ELEMS];
    logic [COUNT_W-1:0] merge_tally;
    logic [1:0]         cur_mode;

    ufc_pkg::t_out_beat pending_results[$];

    int err_count    = 0;
    int items_sent   = 0;
    int joined_seen  = 0;
    int phases_run   = 0;
    int in_gap_pct   = 0;
    int out_stall_pct = 0;
    logic [ELEM_W-1:0] chain_cursor = '0;

    union_find_connectivity_core #(
        .SET_COUNT (ELEMS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // root walk, bounded so that a loop left by a scheme change still ends
    function automatic logic [ELEM_W-1:0] find_root(input logic [ELEM_W-1:0] x);
        logic [ELEM_W-1:0] node;
        logic              stop;
        node = x;
        stop = 1'b0;
        for (int hop = 0; hop < ELEMS; hop++) begin
            if (!stop) begin
                if (link_mem[node] == node)
                    stop = 1'b1;
                else
                    node = link_mem[node];
            end
        end
        return node;
    endfunction

    // apply one pair to the predicted stores; 7-bit indices are always in range
    function automatic ufc_pkg::t_out_beat resolve_pair(input logic [ELEM_W-1:0] a,
                                                        input logic [ELEM_W-1:0] b);
        logic [ELEM_W-1:0]  from_lbl;
        logic [ELEM_W-1:0]  to_lbl;
        logic [ELEM_W-1:0]  ra;
        logic [ELEM_W-1:0]  rb;
        logic [SIZE_W:0]    sum;
        logic               merged;
        ufc_pkg::t_out_beat res;
        merged = 1'b0;
        if (cur_mode == ufc_pkg::MODE_QFIND) begin
            from_lbl = link_mem[a];
            to_lbl   = link_mem[b];
            if (from_lbl != to_lbl) begin
                for (int i = 0; i < ELEMS; i++)
                    if (link_mem[i] == from_lbl)
                        link_mem[i] = to_lbl;
                merged = 1'b1;
            end
        end else begin
            ra = find_root(a);
            rb = find_root(b);
            if (ra != rb) begin
                merged = 1'b1;
                if (cur_mode == ufc_pkg::MODE_QUNION) begin
                    link_mem[ra] = rb;
                end else begin
                    // weighted: smaller under larger, first under second on a tie
                    sum = {1'b0, tree_size[ra]} + {1'b0, tree_size[rb]};
                    if (sum > {1'b0, ufc_pkg::SIZE_MAX})
                        sum = {1'b0, ufc_pkg::SIZE_MAX};
                    if (tree_size[ra] <= tree_size[rb]) begin
                        link_mem[ra]  = rb;
                        tree_size[rb] = sum[SIZE_W-1:0];
                    end else begin
                        link_mem[rb]  = ra;
                        tree_size[ra] = sum[SIZE_W-1:0];
                    end
                end
            end
        end
        // count saturates, joined still reports the merge
        if (merged && merge_tally != ufc_pkg::COUNT_MAX)
            merge_tally = merge_tally + 1'b1;
        res.joined        = merged;
        res.unions_so_far = merge_tally;
        return res;
    endfunction

    // send one pair; prediction is taken at the accepting edge
    task automatic push_pair(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b);
        ufc_pkg::t_in_beat beat;
        int                gap;
        beat.first_element  = a;
        beat.second_element = b;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        pending_results.push_back(resolve_pair(a, b));
        items_sent++;
        if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
            gap = $urandom_range(1, 16);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // let every pending result come back, then allow the core to settle
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_read(input logic [2:0] addr, output logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // change scheme while idle, and read it back
    task automatic set_scheme(input logic [1:0] m);
        logic [31:0] rd;
        reg_write(MODE_ADDR, {30'b0, m});
        cur_mode = m;
        reg_read(MODE_ADDR, rd);
        if (rd !== {30'b0, m}) begin
            $error("mode readback: expected %0d, got %0d", m, rd);
            err_count++;
        end
    endtask

    // random pair: mostly clustered indices or chains, some across the full range
    task automatic random_pair();
        int pick;
        int base;
        int span;
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            base = $urandom_range(0, ELEMS - 1);
            span = 4 << $urandom_range(0, 5);
            a = ELEM_W'(base + $urandom_range(0, span - 1));
            b = ELEM_W'(base + $urandom_range(0, span - 1));
        end else if (pick < 75) begin
            // chain links build deep trees for the root walks
            a = chain_cursor;
            b = chain_cursor + 1'b1;
            chain_cursor = ($urandom_range(0, 7) == 0) ? ELEM_W'($urandom) : b;
            if ($urandom_range(0, 1) == 1) begin
                b = a;
                a = chain_cursor + 1'b1;
            end
        end else begin
            a = ELEM_W'($urandom);
            b = ($urandom_range(0, 9) == 0) ? a : ELEM_W'($urandom);
        end
        push_pair(a, b);
    endtask

    // result beat checker
    always @(posedge i_clk) begin
        ufc_pkg::t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: joined=%0d unions_so_far=%0d",
                       o_out_data.joined, o_out_data.unions_so_far);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.joined !== want.joined) begin
                    $error("joined: expected %0d, got %0d", want.joined, o_out_data.joined);
                    err_count++;
                end
                if (o_out_data.unions_so_far !== want.unions_so_far) begin
                    $error("unions_so_far: expected %0d, got %0d",
                           want.unions_so_far, o_out_data.unions_so_far);
                    err_count++;
                end
                if (want.joined)
                    joined_seen++;
            end
        end
    end

    // result back-pressure in bursts, at the phase's stall percentage
    initial begin
        int hold;
        hold = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0 && out_stall_pct != 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
                hold = $urandom_range(1, 16) - 1;
                i_out_ready <= 1'b0;
            end else begin
                hold = 0;
                i_out_ready <= 1'b1;
            end
        end
    end

    // reset mode is weighted; extremes of both fields and tree tie-breaks
    task automatic test_reset_weighted();
        push_pair(7'd0, 7'd0);
        push_pair(7'd0, 7'd127);
        push_pair(7'd127, 7'd0);
        push_pair(7'h55, 7'h2A);
        push_pair(7'h2A, 7'h55);
        push_pair(7'd1, 7'd2);
        push_pair(7'd3, 7'd1);
        push_pair(7'd0, 7'd1);
        push_pair(7'd4, 7'd5);
        push_pair(7'd1, 7'd4);
        drain_results();
    endtask

    task automatic test_quick_union();
        set_scheme(ufc_pkg::MODE_QUNION);
        push_pair(7'd10, 7'd11);
        push_pair(7'd11, 7'd12);
        push_pair(7'd12, 7'd13);
        push_pair(7'd10, 7'd13);
        push_pair(7'd13, 7'd0);
        push_pair(7'd127, 7'd126);
        drain_results();
    endtask

    task automatic test_quick_find();
        set_scheme(ufc_pkg::MODE_QFIND);
        push_pair(7'd20, 7'd21);
        push_pair(7'd21, 7'd22);
        push_pair(7'd20, 7'd22);
        push_pair(7'd0, 7'd20);
        push_pair(7'd127, 7'd127);
        drain_results();
    endtask

    task automatic test_mode_spare();
        set_scheme(MODE_SPARE);
        push_pair(7'd30, 7'd31);
        push_pair(7'd31, 7'd30);
        push_pair(7'd32, 7'd30);
        drain_results();
    endtask

    // random phases, each under its own scheme and idling level
    task automatic test_random_phases();
        logic [1:0] order [6];
        int         pcts  [4];
        int         n;
        order = '{ufc_pkg::MODE_WEIGHTED, ufc_pkg::MODE_QFIND, ufc_pkg::MODE_QUNION,
                  MODE_SPARE, ufc_pkg::MODE_QUNION, ufc_pkg::MODE_QFIND};
        pcts  = '{0, 10, 30, 60};
        for (int ph = 0; ph < 12; ph++) begin
            set_scheme(ph < 6 ? order[ph] : 2'($urandom_range(0, 3)));
            in_gap_pct    = pcts[$urandom_range(0, 3)];
            out_stall_pct = pcts[$urandom_range(0, 3)];
            n = $urandom_range(60, 110);
            repeat (n) random_pair();
            drain_results();
            phases_run++;
        end
    endtask

    // closing stretch at full rate, no idling on either side
    task automatic test_full_rate_tail();
        in_gap_pct    = 0;
        out_stall_pct = 0;
        set_scheme(ufc_pkg::MODE_WEIGHTED);
        repeat (80) random_pair();
        drain_results();
        set_scheme(ufc_pkg::MODE_QUNION);
        repeat (70) random_pair();
        drain_results();
        phases_run += 2;
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        for (int i = 0; i < ELEMS; i++) begin
            link_mem[i]  = ELEM_W'(i);
            tree_size[i] = ufc_pkg::SIZE_ONE;
        end
        merge_tally = '0;
        cur_mode    = ufc_pkg::MODE_WEIGHTED;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_weighted();
        test_quick_union();
        test_quick_find();
        test_mode_spare();
        test_random_phases();
        test_full_rate_tail();

        $display("Sent %0d pairs over %0d random phases across all four mode values;",
                 items_sent, phases_run);
        $display("%0d beats reported a merge, final union count %0d.",
                 joined_seen, merge_tally);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
